>>> rtl/core/fhd_pkg.sv
// Frame header deframer: shared types, codes and constants.
// Used by every module of the deframer; depends on nothing.
`default_nettype none

package fhd_pkg;

  // Width of the length field that the block can carry
  localparam int LENGTH_BITS = 32;
  localparam logic [63:0] LEN_LIMIT = 64'((64'd1 << LENGTH_BITS) - 64'd1);

  localparam logic [7:0] MAGIC_FIRST  = 8'h51;
  localparam logic [7:0] MAGIC_SECOND = 8'h4c;

  // Header byte positions
  localparam logic [2:0] POS_MAGIC_FIRST  = 3'd0;
  localparam logic [2:0] POS_MAGIC_SECOND = 3'd1;
  localparam logic [2:0] POS_VERSION      = 3'd2;
  localparam logic [2:0] POS_TYPE         = 3'd3;
  localparam logic [2:0] POS_LEN_0        = 3'd4;
  localparam logic [2:0] POS_LEN_1        = 3'd5;
  localparam logic [2:0] POS_LEN_2        = 3'd6;
  localparam logic [2:0] POS_LEN_LAST     = 3'd7;

  // Event codes
  localparam logic [1:0] EV_HEADER  = 2'd0;
  localparam logic [1:0] EV_PAYLOAD = 2'd1;
  localparam logic [1:0] EV_ERROR   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_VERSION   = 2'd2;
  localparam logic [1:0] ST_TOO_LARGE = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_PROTOCOL_VERSION = 2'd0;
  localparam logic [1:0] REG_TYPE_LOWEST      = 2'd1;
  localparam logic [1:0] REG_TYPE_HIGHEST     = 2'd2;
  localparam logic [1:0] REG_MAX_PAYLOAD      = 2'd3;

  typedef struct packed {
    logic [7:0]  protocol_version;
    logic [7:0]  type_lowest;
    logic [7:0]  type_highest;
    logic [31:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [1:0]  status;
    logic [7:0]  frame_kind;
    logic [31:0] payload_bytes;
    logic [7:0]  payload_data;
    logic        last;
  } res_t;

  typedef struct packed {
    logic main_valid;
    logic skid_valid;
  } buf_status_t;

endpackage

`default_nettype wire

>>> rtl/core/fhd_cfg_regs.sv
// Frame header deframer: configuration register file.
// Depends on fhd_pkg for the register indexes and the cfg_t struct.
`default_nettype none

module fhd_cfg_regs import fhd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.protocol_version <= 8'd1;
      cfg.type_lowest      <= 8'd1;
      cfg.type_highest     <= 8'd255;
      cfg.max_payload      <= 32'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROTOCOL_VERSION: cfg.protocol_version <= cfg_data[7:0];
        REG_TYPE_LOWEST:      cfg.type_lowest      <= cfg_data[7:0];
        REG_TYPE_HIGHEST:     cfg.type_highest     <= cfg_data[7:0];
        REG_MAX_PAYLOAD:      cfg.max_payload      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/fhd_parser.sv
// Frame header deframer: header checker and payload counter.
// Holds the parse state and forms at most one result per byte; depends on fhd_pkg.
`default_nettype none

module fhd_parser import fhd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       take,
  input  wire logic [7:0] data_byte,
  output logic            res_valid,
  output res_t            res
);

  logic [2:0]  pos;
  logic [2:0]  pos_next;
  logic        in_payload;
  logic        in_payload_next;
  logic [7:0]  held_kind;
  logic [7:0]  held_kind_next;
  logic [31:0] held_length;
  logic [31:0] held_length_next;
  logic [31:0] bytes_left;
  logic [31:0] bytes_left_next;

  logic [31:0] left_dec;
  logic [31:0] len_new;
  logic        too_large;

  assign left_dec  = bytes_left - 32'd1;
  assign len_new   = {held_length[23:0], data_byte};
  assign too_large = (len_new > cfg.max_payload) || ({32'd0, len_new} > LEN_LIMIT);

  always_comb begin
    pos_next         = pos;
    in_payload_next  = in_payload;
    held_kind_next   = held_kind;
    held_length_next = held_length;
    bytes_left_next  = bytes_left;
    res_valid        = 1'b0;
    res              = '0;

    if (in_payload) begin
      bytes_left_next   = left_dec;
      in_payload_next   = (left_dec != 32'd0);
      res_valid         = 1'b1;
      res.event_res     = EV_PAYLOAD;
      res.frame_kind    = held_kind;
      res.payload_bytes = held_length;
      res.payload_data  = data_byte;
      res.last          = (left_dec == 32'd0);
    end else begin
      pos_next = pos + 3'd1;
      unique case (pos)
        POS_MAGIC_FIRST: begin
          if (data_byte != MAGIC_FIRST) begin
            res_valid  = 1'b1;
            res.status = ST_INVALID;
          end
        end
        POS_MAGIC_SECOND: begin
          if (data_byte != MAGIC_SECOND) begin
            res_valid  = 1'b1;
            res.status = ST_INVALID;
          end
        end
        POS_VERSION: begin
          if (data_byte != cfg.protocol_version) begin
            res_valid  = 1'b1;
            res.status = ST_VERSION;
          end
        end
        POS_TYPE: begin
          if (data_byte < cfg.type_lowest || data_byte > cfg.type_highest) begin
            res_valid  = 1'b1;
            res.status = ST_INVALID;
          end else begin
            held_kind_next   = data_byte;
            held_length_next = 32'd0;
          end
        end
        POS_LEN_0, POS_LEN_1, POS_LEN_2: begin
          held_length_next = len_new;
        end
        POS_LEN_LAST: begin
          held_length_next = len_new;
          res_valid        = 1'b1;
          if (too_large) begin
            res.status        = ST_TOO_LARGE;
            res.frame_kind    = held_kind;
            res.payload_bytes = len_new;
          end else begin
            bytes_left_next   = len_new;
            in_payload_next   = (len_new != 32'd0);
            res.event_res     = EV_HEADER;
            res.frame_kind    = held_kind;
            res.payload_bytes = len_new;
            res.last          = (len_new == 32'd0);
          end
        end
        default: ;
      endcase
      // Any error, and the end of a header, start a new hunt at the next byte
      if (res_valid) begin
        pos_next = POS_MAGIC_FIRST;
      end
      if (res_valid && res.status != ST_OK) begin
        res.event_res   = EV_ERROR;
        res.last        = 1'b1;
        in_payload_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= POS_MAGIC_FIRST;
      in_payload  <= 1'b0;
      held_kind   <= 8'd0;
      held_length <= 32'd0;
      bytes_left  <= 32'd0;
    end else if (take) begin
      pos         <= pos_next;
      in_payload  <= in_payload_next;
      held_kind   <= held_kind_next;
      held_length <= held_length_next;
      bytes_left  <= bytes_left_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/fhd_out_buf.sv
// Frame header deframer: result register with a skid stage.
// Parts the input side from the output stall; depends on fhd_pkg.
`default_nettype none

module fhd_out_buf import fhd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire res_t  push_res,
  output logic       full,
  output logic       out_valid,
  input  wire logic  out_stall,
  output res_t       out_res,
  output buf_status_t st
);

  logic main_valid;
  logic skid_valid;
  res_t main_res;
  res_t skid_res;
  logic pop;

  assign pop       = main_valid && !out_stall;
  assign full      = skid_valid;
  assign out_valid = main_valid;
  assign out_res   = main_res;
  assign st        = '{main_valid: main_valid, skid_valid: skid_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // Input side is stalled: drain the skid item into the main register
      if (pop) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_res <= skid_res;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_res <= push_res;
      end else begin
        skid_res <= push_res;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/frame_header_deframer_unit.sv
// Frame header deframer: top level.
// Ties together fhd_cfg_regs, fhd_parser and fhd_out_buf; depends on fhd_pkg.
//
// Usage:
//   Bytes enter on in_valid/in_stall with data_byte; an item is taken at a
//   clock edge with in_valid high and in_stall low. Each byte yields zero or
//   one result on out_valid/out_stall: header complete, payload byte or
//   header error, with status, frame_kind, payload_bytes, payload_data and
//   last. Header bytes that pass their check give no result.
//   Results reach the outputs from the result register (or via the skid entry).
//   Throughput: one byte per cycle unless in_stall is high; every byte needs one
//   compare and one counter update, combinational from the parse state registers.
//   Stall: the result register is backed by one skid entry. in_stall rises
//   only once both hold a result, i.e. at the earliest in the cycle after the
//   first stalled edge, and drops in the cycle after the output side takes a
//   result again.
//   Reset (rst, synchronous): the block hunts for a header, no results are
//   held, and the registers return to version 1, type range 1..255 and a
//   payload limit of 65536. Write registers through cfg_we/cfg_index/cfg_data
//   only while the block is idle.
`default_nettype none

module frame_header_deframer_unit import fhd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       event_res,
  output logic [1:0]       status,
  output logic [7:0]       frame_kind,
  output logic [31:0]      payload_bytes,
  output logic [7:0]       payload_data,
  output logic             last
);

  cfg_t        cfg;
  logic        take;
  logic        res_valid;
  res_t        res;
  res_t        out_res;
  logic        buf_full;
  buf_status_t buf_st;

  assign in_stall = buf_full;
  assign take     = in_valid && !buf_full;

  fhd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fhd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .take      (take),
    .data_byte (data_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  fhd_out_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (take && res_valid),
    .push_res  (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res),
    .st        (buf_st)
  );

  assign event_res     = out_res.event_res;
  assign status        = out_res.status;
  assign frame_kind    = out_res.frame_kind;
  assign payload_bytes = out_res.payload_bytes;
  assign payload_data  = out_res.payload_data;
  assign last          = out_res.last;

  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    buf_st.skid_valid |-> buf_st.main_valid)
    else $error("skid entry held while result register is empty");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res == EV_ERROR) |-> (last && status != ST_OK))
    else $error("header error without last or status");

  a_ok_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res != EV_ERROR) |-> (status == ST_OK))
    else $error("non-error result carries an error status");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without an output stall");

endmodule

`default_nettype wire

>>> sim/frame_header_deframer_unit_tb.sv
// Self-checking testbench for frame_header_deframer_unit: drives byte streams of
// good, broken and oversized frame headers under random idling on both sides.
// Depends on fhd_pkg and the deframer RTL only.
module frame_header_deframer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fhd_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_PROTOCOL_VERSION;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  event_res;
  logic [1:0]  status;
  logic [7:0]  frame_kind;
  logic [31:0] payload_bytes;
  logic [7:0]  payload_data;
  logic        last;

  frame_header_deframer_unit u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .event_res(event_res), .status(status), .frame_kind(frame_kind),
    .payload_bytes(payload_bytes), .payload_data(payload_data), .last(last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Register copies as last written
  logic [7:0]  want_version = 8'd1;
  logic [7:0]  kind_lo = 8'd1;
  logic [7:0]  kind_hi = 8'd255;
  logic [31:0] len_max = 32'd65536;

  // Parse state of the predicted deframer
  logic [2:0]  hunt_pos = POS_MAGIC_FIRST;
  logic        payload_active = 1'b0;
  logic [7:0]  kind_held = '0;
  logic [31:0] len_held = '0;
  logic [31:0] payload_left = '0;

  res_t        expected_results [$];
  logic [7:0]  pending_bytes [$];
  int          bytes_offered = 0;
  int          bytes_taken = 0;
  int          error_count = 0;

  int          send_idle_max = 10;
  int          recv_idle_max = 10;
  int          send_gap = 0;
  int          stall_left = 0;
  bit          in_taken = 1'b0;
  bit          out_taken = 1'b0;
  bit          hold_off = 1'b0;

  function automatic int draw_idle(int cap);
    if (cap == 0 || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, cap);
  endfunction

  // Advance the predicted parse state by one byte and queue any result
  task automatic deframe_byte(input logic [7:0] b);
    res_t       r;
    logic [1:0] err;
    bit         bad;
    r = '0;
    err = ST_INVALID;
    bad = 1'b0;
    if (payload_active) begin
      payload_left = payload_left - 32'd1;
      r.event_res = EV_PAYLOAD;
      r.status = ST_OK;
      r.frame_kind = kind_held;
      r.payload_bytes = len_held;
      r.payload_data = b;
      r.last = (payload_left == 0);
      if (r.last) payload_active = 1'b0;
      expected_results.push_back(r);
    end else begin
      case (hunt_pos)
        POS_MAGIC_FIRST:  bad = (b != MAGIC_FIRST);
        POS_MAGIC_SECOND: bad = (b != MAGIC_SECOND);
        POS_VERSION: begin
          bad = (b != want_version);
          err = ST_VERSION;
        end
        POS_TYPE: begin
          bad = (b < kind_lo) || (b > kind_hi);
          if (!bad) begin
            kind_held = b;
            len_held = '0;
          end
        end
        POS_LEN_LAST: begin
          len_held = {len_held[23:0], b};
          bad = (len_held > len_max) || ({32'd0, len_held} > LEN_LIMIT);
          err = ST_TOO_LARGE;
        end
        default: len_held = {len_held[23:0], b};
      endcase
      if (bad) begin
        r.event_res = EV_ERROR;
        r.status = err;
        r.last = 1'b1;
        // only an oversized length reports the frame it belonged to
        if (err == ST_TOO_LARGE) begin
          r.frame_kind = kind_held;
          r.payload_bytes = len_held;
        end
        hunt_pos = POS_MAGIC_FIRST;
        expected_results.push_back(r);
      end else if (hunt_pos == POS_LEN_LAST) begin
        r.event_res = EV_HEADER;
        r.status = ST_OK;
        r.frame_kind = kind_held;
        r.payload_bytes = len_held;
        payload_left = len_held;
        payload_active = (len_held != 0);
        r.last = !payload_active;
        hunt_pos = POS_MAGIC_FIRST;
        expected_results.push_back(r);
      end else begin
        hunt_pos = hunt_pos + 3'd1;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  // Sample both handshakes at the rising edge
  always @(posedge clk) begin
    res_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        deframe_byte(data_byte);
        bytes_taken++;
        in_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        out_taken = 1'b1;
        if (expected_results.size() == 0) begin
          $error("result with none expected: event_res %0d status %0d", event_res, status);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("event_res", want.event_res, event_res);
          check_field("status", want.status, status);
          check_field("frame_kind", want.frame_kind, frame_kind);
          check_field("payload_bytes", want.payload_bytes, payload_bytes);
          check_field("payload_data", want.payload_data, payload_data);
          check_field("last", want.last, last);
        end
      end
    end
  end

  // Byte sender: hold the item until taken, then idle for a drawn gap
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        data_byte <= pending_bytes.pop_front();
        in_valid <= 1'b1;
        send_gap = draw_idle(send_idle_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_taken = 1'b0;
  end

  // Result receiver: stall for a drawn count after each item
  always @(negedge clk) begin
    if (out_taken) begin
      stall_left = draw_idle(recv_idle_max);
      out_taken = 1'b0;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_off) begin
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_offered++;
  endtask

  task automatic push_header(input logic [7:0] kind, input logic [31:0] len);
    push_byte(MAGIC_FIRST);
    push_byte(MAGIC_SECOND);
    push_byte(want_version);
    push_byte(kind);
    push_byte(len[31:24]);
    push_byte(len[23:16]);
    push_byte(len[15:8]);
    push_byte(len[7:0]);
  endtask

  function automatic logic [7:0] pick_kind();
    if (kind_lo <= kind_hi) return 8'($urandom_range(kind_lo, kind_hi));
    return 8'($urandom);
  endfunction

  task automatic push_random_segment();
    logic [7:0]  hdr [0:3];
    logic [31:0] len;
    int          pick;
    int          p;
    bit          oversize;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      oversize = 1'b0;
      p = $urandom_range(0, 19);
      if (len_max != '1 && p == 0) begin
        oversize = 1'b1;
        len = $urandom_range(0, 1) ? len_max + 32'd1
                                   : 32'($urandom_range(len_max + 32'd1, 32'hffff_ffff));
      end else if (p == 1 && len_max <= 64) begin
        len = len_max;
      end else begin
        len = $urandom_range(0, len_max < 12 ? len_max : 12);
      end
      push_header(pick_kind(), len);
      if (!oversize)
        for (int i = 0; i < len; i++) push_byte(8'($urandom));
    end else if (pick < 85) begin
      // header cut short by one wrong byte
      hdr = '{MAGIC_FIRST, MAGIC_SECOND, want_version, pick_kind()};
      p = $urandom_range(0, 3);
      if (p == 3) begin
        if (kind_lo > kind_hi) hdr[3] = 8'($urandom);
        else if (kind_lo > 0) hdr[3] = 8'($urandom_range(0, kind_lo - 1));
        else if (kind_hi < 255) hdr[3] = 8'($urandom_range(kind_hi + 1, 255));
        else p = $urandom_range(0, 2);
      end
      if (p < 3) hdr[p] = hdr[p] ^ 8'($urandom_range(1, 255));
      for (int i = 0; i <= p; i++) push_byte(hdr[i]);
    end else begin
      p = $urandom_range(1, 4);
      for (int i = 0; i < p; i++) push_byte(8'($urandom));
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (bytes_taken != bytes_offered || expected_results.size() != 0);
    // let a header still in flight settle
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_PROTOCOL_VERSION: want_version = value[7:0];
      REG_TYPE_LOWEST:      kind_lo = value[7:0];
      REG_TYPE_HIGHEST:     kind_hi = value[7:0];
      REG_MAX_PAYLOAD:      len_max = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int nbytes, input int send_max, input int recv_max,
                           input bit squeeze);
    int target;
    @(posedge clk);
    send_idle_max = send_max;
    recv_idle_max = recv_max;
    target = bytes_offered + nbytes;
    while (bytes_offered < target) push_random_segment();
    if (squeeze) begin
      // hold results back long enough for the block to stall its input
      hold_off = 1'b1;
      repeat (60) @(posedge clk);
      hold_off = 1'b0;
    end
    wait_drained();
  endtask

  initial begin
    logic [7:0] lo;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed bytes at the reset register values
    push_header(8'd1, 32'd0);
    push_header(8'd255, 32'd2);
    push_byte(8'h00);
    push_byte(8'hff);
    push_byte(8'h00);
    push_byte(MAGIC_FIRST);
    push_byte(MAGIC_FIRST);
    push_byte(MAGIC_SECOND);
    push_byte(MAGIC_FIRST);
    push_byte(MAGIC_SECOND);
    push_byte(8'h02);
    push_byte(MAGIC_FIRST);
    push_byte(MAGIC_SECOND);
    push_byte(8'h01);
    push_byte(8'h00);
    push_header(8'h80, 32'hffff_ffff);
    wait_drained();

    write_reg(REG_PROTOCOL_VERSION, 32'd0);
    write_reg(REG_TYPE_LOWEST, 32'd0);
    write_reg(REG_TYPE_HIGHEST, 32'd0);
    write_reg(REG_MAX_PAYLOAD, 32'd0);
    run_phase(100, 10, 10, 1'b0);

    write_reg(REG_PROTOCOL_VERSION, 32'd255);
    write_reg(REG_TYPE_LOWEST, 32'd255);
    write_reg(REG_TYPE_HIGHEST, 32'd255);
    write_reg(REG_MAX_PAYLOAD, 32'hffff_ffff);
    run_phase(120, 3, 10, 1'b1);

    // empty type range: every header that reaches its type byte dies there
    write_reg(REG_TYPE_LOWEST, 32'd200);
    write_reg(REG_TYPE_HIGHEST, 32'd100);
    run_phase(80, 10, 10, 1'b0);

    for (int k = 0; k < 5; k++) begin
      lo = 8'($urandom_range(0, 200));
      write_reg(REG_PROTOCOL_VERSION, $urandom_range(0, 255));
      write_reg(REG_TYPE_LOWEST, {24'd0, lo});
      write_reg(REG_TYPE_HIGHEST, $urandom_range(lo, 255));
      write_reg(REG_MAX_PAYLOAD, ($urandom_range(0, 2) == 0) ? $urandom
                                                             : $urandom_range(0, 40));
      run_phase(120, (k == 1) ? 0 : 10, (k == 1) ? 0 : 10, k == 3);
    end

    write_reg(REG_PROTOCOL_VERSION, 32'd1);
    write_reg(REG_TYPE_LOWEST, 32'd1);
    write_reg(REG_TYPE_HIGHEST, 32'd255);
    write_reg(REG_MAX_PAYLOAD, 32'd65536);
    run_phase(100, 10, 10, 1'b0);

    repeat (10) @(negedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("frame_header_deframer_unit_tb: done, clean");
    end else begin
      $display("frame_header_deframer_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("frame_header_deframer_unit_tb: done, errors");
    $finish;
  end

endmodule
